// ----- hw/rtl/olst_pkg.sv -----
`default_nettype none

package olst_pkg;

	// field widths of the command and result items
	localparam int CMD_W   = 3;
	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic              latch;      // capture the accepted command
		logic              append;     // write value at count, count up
		logic              pop;        // count down
		logic              ptr_top;    // pointer to count - 1
		logic              ptr_next;   // pointer to position + 1
		logic              ptr_zero;   // pointer to entry zero
		logic              rd_issue;   // read the store at the pointer
		logic              ptr_dec;
		logic              ptr_inc;
		logic              put_val;    // write value at position, count up
		logic              set_res;    // capture status for this command
		logic [STAT_W-1:0] res_status;
		logic              set_found;  // capture index of the matching read
		logic              publish;    // load the result register
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             bad_pos;
		logic             erase_last;
		logic             ptr_at_pos;
		logic             ptr_at_last;
		logic             ptr_end;
		logic             match;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/olst_if.sv -----
`default_nettype none

// command channel
interface olst_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [olst_pkg::CMD_W-1:0]    command;
	logic [olst_pkg::POS_W-1:0]    position;
	logic signed [olst_pkg::VAL_W-1:0] value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink (input valid, input command, input position, input value, output ready);
endinterface

// result channel
interface olst_res_if;
	logic                          valid;
	logic                          ready;
	logic [olst_pkg::STAT_W-1:0]   status;
	logic [olst_pkg::POS_W-1:0]    found_index;
	logic [olst_pkg::COUNT_W-1:0]  element_count;

	modport source (output valid, output status, output found_index, output element_count,
		input ready);
	modport sink (input valid, input status, input found_index, input element_count,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/olst_ram.sv -----
`default_nettype none

module olst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/olst_ctrl.sv -----
`default_nettype none

module olst_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output olst_pkg::dp_cmd_t       cmd,
	input  wire olst_pkg::dp_stat_t stat
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_UP     = 8'b0000_0100,
		S_DN     = 8'b0000_1000,
		S_FIND   = 8'b0001_0000,
		S_DRAIN  = 8'b0010_0000,
		S_PUTV   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_res    = 1'b1;
				cmd.res_status = olst_pkg::ST_OK;
				state_d        = S_DONE;
				case (stat.cmd)
					olst_pkg::CMD_APPEND: begin
						if (stat.full) begin
							cmd.res_status = olst_pkg::ST_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					olst_pkg::CMD_POP: begin
						if (stat.empty) begin
							cmd.res_status = olst_pkg::ST_EMPTY;
						end else begin
							cmd.pop = 1'b1;
						end
					end
					olst_pkg::CMD_INSERT: begin
						if (stat.full) begin
							cmd.res_status = olst_pkg::ST_FULL;
						end else if (stat.bad_pos) begin
							cmd.res_status = olst_pkg::ST_BADPOS;
						end else begin
							cmd.set_res = 1'b0;
							cmd.ptr_top = 1'b1;
							state_d     = S_UP;
						end
					end
					olst_pkg::CMD_ERASE: begin
						if (stat.bad_pos) begin
							cmd.res_status = olst_pkg::ST_BADPOS;
						end else if (stat.erase_last) begin
							cmd.pop = 1'b1;
						end else begin
							cmd.set_res  = 1'b0;
							cmd.ptr_next = 1'b1;
							state_d      = S_DN;
						end
					end
					olst_pkg::CMD_FIND: begin
						if (stat.empty) begin
							cmd.res_status = olst_pkg::ST_NOTFOUND;
						end else begin
							cmd.set_res  = 1'b0;
							cmd.ptr_zero = 1'b1;
							state_d      = S_FIND;
						end
					end
					default: begin
						cmd.res_status = olst_pkg::ST_OK;
					end
				endcase
			end
			// shift up: read from the top down to position
			S_UP: begin
				cmd.rd_issue = 1'b1;
				if (stat.ptr_at_pos) begin
					state_d = S_DRAIN;
				end else begin
					cmd.ptr_dec = 1'b1;
				end
			end
			// shift down: read from position + 1 up to the last element
			S_DN: begin
				cmd.rd_issue = 1'b1;
				if (stat.ptr_at_last) begin
					state_d = S_DRAIN;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			// last moved element is written back in this cycle
			S_DRAIN: begin
				if (stat.cmd == olst_pkg::CMD_INSERT) begin
					state_d = S_PUTV;
				end else begin
					cmd.pop        = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = olst_pkg::ST_OK;
					state_d        = S_DONE;
				end
			end
			S_PUTV: begin
				cmd.put_val    = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = olst_pkg::ST_OK;
				state_d        = S_DONE;
			end
			// linear search, compare uses the read data in the cycle after the read
			S_FIND: begin
				if (stat.match) begin
					cmd.set_res    = 1'b1;
					cmd.set_found  = 1'b1;
					cmd.res_status = olst_pkg::ST_OK;
					state_d        = S_DONE;
				end else if (stat.ptr_end) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = olst_pkg::ST_NOTFOUND;
					state_d        = S_DONE;
				end else begin
					cmd.rd_issue = 1'b1;
					cmd.ptr_inc  = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/olst_dp.sv -----
`default_nettype none

module olst_dp #(
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire olst_pkg::dp_cmd_t                cmd,
	output olst_pkg::dp_stat_t                    stat,
	input  wire logic [olst_pkg::CMD_W-1:0]       in_command,
	input  wire logic [olst_pkg::POS_W-1:0]       in_position,
	input  wire logic signed [olst_pkg::VAL_W-1:0] in_value,
	output logic [olst_pkg::STAT_W-1:0]           out_status,
	output logic [olst_pkg::POS_W-1:0]            out_found_index,
	output logic [olst_pkg::COUNT_W-1:0]          out_element_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

	logic [olst_pkg::CMD_W-1:0]  cmd_q;
	logic [olst_pkg::POS_W-1:0]  pos_q;
	logic [olst_pkg::VAL_W-1:0]  val_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               ptr_q;
	logic                        rd_vld_s1;
	logic [AW-1:0]               rd_addr_s1;
	logic [olst_pkg::STAT_W-1:0] status_q;
	logic [AW-1:0]               found_q;
	logic [olst_pkg::STAT_W-1:0] out_status_q;
	logic [olst_pkg::POS_W-1:0]  out_found_q;
	logic [olst_pkg::COUNT_W-1:0] out_count_q;

	logic [CW-1:0]               pos_ext;
	logic [CW-1:0]               count_m1;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [olst_pkg::VAL_W-1:0]  wdata;
	logic [olst_pkg::VAL_W-1:0]  rdata;

	assign pos_ext  = CW'(pos_q);
	assign count_m1 = count_q - CW'(1);

	// status toward the controller
	always_comb begin
		stat.cmd         = cmd_q;
		stat.full        = (count_q == CW'(DEPTH));
		stat.empty       = (count_q == '0);
		stat.bad_pos     = (PW'(pos_q) >= PW'(count_q));
		stat.erase_last  = (pos_ext == count_m1);
		stat.ptr_at_pos  = (ptr_q == pos_ext);
		stat.ptr_at_last = (ptr_q == count_m1);
		stat.ptr_end     = (ptr_q == count_q);
		stat.match       = rd_vld_s1 && (rdata == val_q);
	end

	// write port: new value, or the element read in the previous cycle moved by one
	always_comb begin
		we    = 1'b0;
		waddr = rd_addr_s1;
		wdata = rdata;
		if (cmd.append) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = val_q;
		end else if (cmd.put_val) begin
			we    = 1'b1;
			waddr = AW'(pos_q);
			wdata = val_q;
		end else if (rd_vld_s1 && cmd_q == olst_pkg::CMD_INSERT) begin
			we    = 1'b1;
			waddr = rd_addr_s1 + AW'(1);
		end else if (rd_vld_s1 && cmd_q == olst_pkg::CMD_ERASE) begin
			we    = 1'b1;
			waddr = rd_addr_s1 - AW'(1);
		end
	end

	olst_ram #(
		.WIDTH (olst_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_issue),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// element count and read pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.append || cmd.put_val) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_m1;
			end
		end
	end

	// command fields, walk pointer and results
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= in_command;
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (cmd.ptr_top) begin
			ptr_q <= count_m1;
		end else if (cmd.ptr_next) begin
			ptr_q <= pos_ext + CW'(1);
		end else if (cmd.ptr_zero) begin
			ptr_q <= '0;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - CW'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + CW'(1);
		end
		rd_addr_s1 <= ptr_q[AW-1:0];
		if (cmd.set_res) begin
			status_q <= cmd.res_status;
			found_q  <= cmd.set_found ? rd_addr_s1 : '0;
		end
		if (cmd.publish) begin
			out_status_q <= status_q;
			out_found_q  <= olst_pkg::POS_W'(found_q);
			out_count_q  <= olst_pkg::COUNT_W'(count_q);
		end
	end

	assign out_status        = out_status_q;
	assign out_found_index   = out_found_q;
	assign out_element_count = out_count_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_list_store_top.sv -----
// Ordered list of signed 32-bit values in a store of DEPTH entries.
// cmd channel: command (append, remove last, insert at position,
// erase at position, find value), position and value; a transfer takes
// place when valid and ready are both high. res channel: status,
// found_index and element_count after the command, one result per command.
// One command is worked at a time; ready is high only while the block idles.
// Insert, erase and find walk the store through its single registered read
// port, one element a cycle. Ready returns in the same cycle that the result
// becomes valid, so a new command is not taken before the previous one has
// had its result loaded.
// Reset empties the list (count zero); store contents are not cleared and
// no clearing pass is needed. A finished result waits in an output register
// while the receiver stalls; the next command is accepted meanwhile and
// holds at its end until the previous result has been taken.
`default_nettype none

module ordered_list_store_top #(
	parameter int DEPTH = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	olst_cmd_if.sink  cmd,
	olst_res_if.source res
);

	olst_pkg::dp_cmd_t  dp_cmd;
	olst_pkg::dp_stat_t dp_stat;

	olst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	olst_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (dp_cmd),
		.stat              (dp_stat),
		.in_command        (cmd.command),
		.in_position       (cmd.position),
		.in_value          (cmd.value),
		.out_status        (res.status),
		.out_found_index   (res.found_index),
		.out_element_count (res.element_count)
	);

endmodule

`default_nettype wire
